### sv/rmq_pkg.sv
package rmq_pkg;

    // Pivot selection: trace branch or diagonal index 0..2
    typedef enum logic [1:0] {
        PIV_TRACE = 2'd0,
        PIV_X     = 2'd1,
        PIV_Y     = 2'd2,
        PIV_Z     = 2'd3
    } piv_t;

endpackage

### sv/rotation_matrix_to_quaternion.sv
// Path from input transfer to result valid: front stage, bit-per-stage root, divider,
// output queue. Throughput: one matrix per cycle while in_stall is low.
// in_stall rises only while the two-entry output queue is full, out_stall is high
// and a result waits at the divider output; then the whole pipe holds.
// Reset clears all valid bits; payload registers are not reset.
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] m00,
    input  logic signed [DATA_WIDTH-1:0] m01,
    input  logic signed [DATA_WIDTH-1:0] m02,
    input  logic signed [DATA_WIDTH-1:0] m10,
    input  logic signed [DATA_WIDTH-1:0] m11,
    input  logic signed [DATA_WIDTH-1:0] m12,
    input  logic signed [DATA_WIDTH-1:0] m20,
    input  logic signed [DATA_WIDTH-1:0] m21,
    input  logic signed [DATA_WIDTH-1:0] m22,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] quat_w,
    output logic signed [DATA_WIDTH-1:0] quat_x,
    output logic signed [DATA_WIDTH-1:0] quat_y,
    output logic signed [DATA_WIDTH-1:0] quat_z
);
    import rmq_pkg::*;

    localparam int AW   = DATA_WIDTH + 3;            // root argument width
    localparam int RT_W = (AW + FRAC_BITS + 1) / 2;  // root width
    localparam int SQ_IN = 2 * RT_W;
    localparam int NW   = DATA_WIDTH + 2;            // signed numerator width
    localparam int MW   = NW - 1;                    // magnitude width
    localparam int DNW  = MW + FRAC_BITS + 1;        // dividend width
    localparam int DDW  = RT_W + 1;                  // divisor width
    localparam int QW   = DATA_WIDTH;                // unsigned quotient width
    localparam int SB1  = 2 + 3 * NW;
    localparam int DSB  = 2 + RT_W;

    logic pipe_en;
    logic                 f_valid;
    piv_t                 f_piv;
    logic [AW-1:0]        f_arg;
    logic signed [NW-1:0] f_n0, f_n1, f_n2;
    logic                 s_valid;
    logic [RT_W-1:0]      s_root;
    logic [SB1-1:0]       s_side;
    piv_t                 s_piv;
    logic signed [NW-1:0] s_n0, s_n1, s_n2;
    logic [MW-1:0]        mag0, mag1, mag2;
    logic [DDW-1:0]       den;
    logic                 d_valid [3];
    logic [QW-1:0]        d_quo [3];
    logic                 d_big [3];
    logic [DSB-1:0]       d_side [3];
    logic                 neg0_reg [QW+1];
    logic                 neg1_reg [QW+1];
    logic                 neg2_reg [QW+1];
    logic signed [DATA_WIDTH-1:0] q_fin [3];
    logic signed [DATA_WIDTH-1:0] half, w_o, x_o, y_o, z_o;
    piv_t                 o_piv;
    logic [RT_W-1:0]      o_root;
    logic                 o_zero;
    logic [1:0]           cnt_reg, cnt_next;
    logic signed [DATA_WIDTH-1:0] b0w_reg, b0x_reg, b0y_reg, b0z_reg;
    logic signed [DATA_WIDTH-1:0] b1w_reg, b1x_reg, b1y_reg, b1z_reg;
    logic                 push, pop;

    // Pipe holds only when the queue is full, stalled, and a result waits at the end
    assign pipe_en  = (cnt_reg != 2'd2) || !out_stall || !d_valid[0];
    assign in_stall = !pipe_en;

    rmq_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_valid(in_valid),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22),
        .out_valid(f_valid), .piv(f_piv), .arg(f_arg),
        .n0(f_n0), .n1(f_n1), .n2(f_n2)
    );

    rmq_sqrt #(.IN_W(SQ_IN), .OUT_W(RT_W), .SB_W(SB1)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_valid(f_valid),
        .rad(SQ_IN'(f_arg) << FRAC_BITS),
        .side({f_piv, f_n0, f_n1, f_n2}),
        .out_valid(s_valid), .root(s_root), .side_out(s_side)
    );

    // Split root-stage sideband and form magnitudes
    always_comb
    begin
        s_piv = piv_t'(s_side[SB1-1 -: 2]);
        s_n0  = s_side[3*NW-1 -: NW];
        s_n1  = s_side[2*NW-1 -: NW];
        s_n2  = s_side[NW-1:0];
        mag0  = MW'(s_n0 < 0 ? -s_n0 : s_n0);
        mag1  = MW'(s_n1 < 0 ? -s_n1 : s_n1);
        mag2  = MW'(s_n2 < 0 ? -s_n2 : s_n2);
        den   = {s_root, 1'b0};
    end

    // Three dividers in lockstep; root zero makes den zero, forcing big
    rmq_div #(.NUM_W(DNW), .DEN_W(DDW), .Q_W(QW), .SB_W(DSB)) u_div0 (
        .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_valid(s_valid),
        .num((DNW'(mag0) << FRAC_BITS) + DNW'(s_root)), .den(den),
        .side({s_piv, s_root}),
        .out_valid(d_valid[0]), .quo(d_quo[0]), .big(d_big[0]), .side_out(d_side[0])
    );
    rmq_div #(.NUM_W(DNW), .DEN_W(DDW), .Q_W(QW), .SB_W(DSB)) u_div1 (
        .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_valid(s_valid),
        .num((DNW'(mag1) << FRAC_BITS) + DNW'(s_root)), .den(den),
        .side({s_piv, s_root}),
        .out_valid(d_valid[1]), .quo(d_quo[1]), .big(d_big[1]), .side_out(d_side[1])
    );
    rmq_div #(.NUM_W(DNW), .DEN_W(DDW), .Q_W(QW), .SB_W(DSB)) u_div2 (
        .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_valid(s_valid),
        .num((DNW'(mag2) << FRAC_BITS) + DNW'(s_root)), .den(den),
        .side({s_piv, s_root}),
        .out_valid(d_valid[2]), .quo(d_quo[2]), .big(d_big[2]), .side_out(d_side[2])
    );

    // Signs of numerators ride along with the dividers
    assign neg0_reg[0] = s_n0 < 0;
    assign neg1_reg[0] = s_n1 < 0;
    assign neg2_reg[0] = s_n2 < 0;
    for (genvar g = 0; g < QW; g++)
    begin : g_sign
        always_ff @(posedge clk)
        begin
            if (pipe_en)
            begin
                neg0_reg[g+1] <= neg0_reg[g];
                neg1_reg[g+1] <= neg1_reg[g];
                neg2_reg[g+1] <= neg2_reg[g];
            end
        end
    end

    // Saturate signed quotients
    always_comb
    begin
        logic [QW-1:0] lim_p;
        lim_p = {1'b0, {(QW-1){1'b1}}};
        q_fin[0] = (d_big[0] || d_quo[0] > lim_p) ?
                   (neg0_reg[QW] ? {1'b1, {(QW-1){1'b0}}} : lim_p) :
                   (neg0_reg[QW] ? -d_quo[0] : d_quo[0]);
        q_fin[1] = (d_big[1] || d_quo[1] > lim_p) ?
                   (neg1_reg[QW] ? {1'b1, {(QW-1){1'b0}}} : lim_p) :
                   (neg1_reg[QW] ? -d_quo[1] : d_quo[1]);
        q_fin[2] = (d_big[2] || d_quo[2] > lim_p) ?
                   (neg2_reg[QW] ? {1'b1, {(QW-1){1'b0}}} : lim_p) :
                   (neg2_reg[QW] ? -d_quo[2] : d_quo[2]);
    end

    // Place components by pivot
    always_comb
    begin
        logic [RT_W:0] h;
        o_piv  = piv_t'(d_side[0][DSB-1 -: 2]);
        o_root = d_side[0][RT_W-1:0];
        o_zero = (o_root == '0);
        h      = ({1'b0, o_root} + 1'b1) >> 1;
        half   = (h > (RT_W+1)'({1'b0, {(DATA_WIDTH-1){1'b1}}})) ?
                 {1'b0, {(DATA_WIDTH-1){1'b1}}} : DATA_WIDTH'(h);
        w_o = '0; x_o = '0; y_o = '0; z_o = '0;
        case (o_piv)
            PIV_TRACE:
            begin
                w_o = half; x_o = q_fin[0]; y_o = q_fin[1]; z_o = q_fin[2];
            end
            PIV_X:
            begin
                x_o = half;
                if (!o_zero)
                begin
                    w_o = q_fin[0]; y_o = q_fin[1]; z_o = q_fin[2];
                end
            end
            PIV_Y:
            begin
                y_o = half;
                if (!o_zero)
                begin
                    w_o = q_fin[0]; z_o = q_fin[1]; x_o = q_fin[2];
                end
            end
            default:
            begin
                z_o = half;
                if (!o_zero)
                begin
                    w_o = q_fin[0]; x_o = q_fin[1]; y_o = q_fin[2];
                end
            end
        endcase
    end

    // Two-entry output queue
    assign push = pipe_en && d_valid[0];
    assign pop  = (cnt_reg != 2'd0) && !out_stall;
    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        // head entry: new result when it lands at the front, else shift up
        if (push && ((cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop)))
        begin
            b0w_reg <= w_o; b0x_reg <= x_o; b0y_reg <= y_o; b0z_reg <= z_o;
        end
        else if (pop)
        begin
            b0w_reg <= b1w_reg; b0x_reg <= b1x_reg;
            b0y_reg <= b1y_reg; b0z_reg <= b1z_reg;
        end
        // second entry
        if (push && ((cnt_reg == 2'd2) || (cnt_reg == 2'd1 && !pop)))
        begin
            b1w_reg <= w_o; b1x_reg <= x_o; b1y_reg <= y_o; b1z_reg <= z_o;
        end
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign quat_w = b0w_reg;
    assign quat_x = b0x_reg;
    assign quat_y = b0y_reg;
    assign quat_z = b0z_reg;

endmodule

### sv/rmq_front.sv
// Front end: trace, pivot choice, root argument and the three numerators
module rmq_front #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [DATA_WIDTH-1:0] m00,
    input  logic signed [DATA_WIDTH-1:0] m01,
    input  logic signed [DATA_WIDTH-1:0] m02,
    input  logic signed [DATA_WIDTH-1:0] m10,
    input  logic signed [DATA_WIDTH-1:0] m11,
    input  logic signed [DATA_WIDTH-1:0] m12,
    input  logic signed [DATA_WIDTH-1:0] m20,
    input  logic signed [DATA_WIDTH-1:0] m21,
    input  logic signed [DATA_WIDTH-1:0] m22,
    output logic                         out_valid,
    output rmq_pkg::piv_t                piv,
    output logic [DATA_WIDTH+2:0]        arg,
    output logic signed [DATA_WIDTH+1:0] n0,
    output logic signed [DATA_WIDTH+1:0] n1,
    output logic signed [DATA_WIDTH+1:0] n2
);
    import rmq_pkg::*;

    localparam int SW = DATA_WIDTH + 3;

    logic signed [SW-1:0] trace;
    logic signed [SW-1:0] arg_s;
    logic signed [SW-1:0] one;
    logic [1:0]           idx;
    piv_t                 piv_next;
    logic signed [DATA_WIDTH+1:0] n0_next, n1_next, n2_next;
    logic                 valid_reg;
    piv_t                 piv_reg;
    logic [SW-1:0]        arg_reg;
    logic signed [DATA_WIDTH+1:0] n0_reg, n1_reg, n2_reg;

    // Branch select and numerators
    always_comb
    begin
        one   = SW'(1) <<< FRAC_BITS;
        trace = SW'(m00) + SW'(m11) + SW'(m22);
        idx   = 2'd0;
        if (m11 > m00)
            idx = 2'd1;
        if ((idx == 2'd0 && m22 > m00) || (idx == 2'd1 && m22 > m11))
            idx = 2'd2;
        arg_s = '0;
        n0_next = '0;
        n1_next = '0;
        n2_next = '0;
        piv_next = PIV_TRACE;
        if (trace > 0)
        begin
            arg_s   = trace + one;
            n0_next = (DATA_WIDTH+2)'(m21) - (DATA_WIDTH+2)'(m12);
            n1_next = (DATA_WIDTH+2)'(m02) - (DATA_WIDTH+2)'(m20);
            n2_next = (DATA_WIDTH+2)'(m10) - (DATA_WIDTH+2)'(m01);
        end
        else
        begin
            // n0 -> w, n1 -> q_j, n2 -> q_k
            case (idx)
                2'd0:
                begin
                    piv_next = PIV_X;
                    arg_s   = SW'(m00) - SW'(m11) - SW'(m22) + one;
                    n0_next = (DATA_WIDTH+2)'(m21) - (DATA_WIDTH+2)'(m12);
                    n1_next = (DATA_WIDTH+2)'(m01) + (DATA_WIDTH+2)'(m10);
                    n2_next = (DATA_WIDTH+2)'(m02) + (DATA_WIDTH+2)'(m20);
                end
                2'd1:
                begin
                    piv_next = PIV_Y;
                    arg_s   = SW'(m11) - SW'(m22) - SW'(m00) + one;
                    n0_next = (DATA_WIDTH+2)'(m02) - (DATA_WIDTH+2)'(m20);
                    n1_next = (DATA_WIDTH+2)'(m12) + (DATA_WIDTH+2)'(m21);
                    n2_next = (DATA_WIDTH+2)'(m10) + (DATA_WIDTH+2)'(m01);
                end
                default:
                begin
                    piv_next = PIV_Z;
                    arg_s   = SW'(m22) - SW'(m00) - SW'(m11) + one;
                    n0_next = (DATA_WIDTH+2)'(m10) - (DATA_WIDTH+2)'(m01);
                    n1_next = (DATA_WIDTH+2)'(m20) + (DATA_WIDTH+2)'(m02);
                    n2_next = (DATA_WIDTH+2)'(m21) + (DATA_WIDTH+2)'(m12);
                end
            endcase
            if (arg_s < 0)
                arg_s = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            piv_reg <= piv_next;
            arg_reg <= arg_s;
            n0_reg  <= n0_next;
            n1_reg  <= n1_next;
            n2_reg  <= n2_next;
        end
    end

    assign out_valid = valid_reg;
    assign piv = piv_reg;
    assign arg = arg_reg;
    assign n0 = n0_reg;
    assign n1 = n1_reg;
    assign n2 = n2_reg;

endmodule

### sv/rmq_sqrt.sv
// Pipelined restoring square root, one result bit per stage
module rmq_sqrt #(
    parameter int IN_W  = 36,
    parameter int OUT_W = 18,
    parameter int SB_W  = 40
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [IN_W-1:0] rad,
    input  logic [SB_W-1:0] side,
    output logic            out_valid,
    output logic [OUT_W-1:0] root,
    output logic [SB_W-1:0] side_out
);
    localparam int RW = OUT_W + 2;

    logic [OUT_W:0]            v_reg;
    logic [2*OUT_W-1:0]        n_reg [OUT_W+1];
    logic [RW-1:0]             r_reg [OUT_W+1];
    logic [OUT_W-1:0]          q_reg [OUT_W+1];
    logic [SB_W-1:0]           sb_reg [OUT_W+1];

    assign v_reg[0]  = in_valid;
    assign n_reg[0]  = (2*OUT_W)'(rad);
    assign r_reg[0]  = '0;
    assign q_reg[0]  = '0;
    assign sb_reg[0] = side;

    // Stage s brings down two radicand bits and decides one root bit
    for (genvar s = 0; s < OUT_W; s++)
    begin : g_stage
        logic [RW-1:0]    rem_next;
        logic [RW-1:0]    trial;
        logic [OUT_W-1:0] q_next;
        always_comb
        begin
            rem_next = {r_reg[s][RW-3:0], n_reg[s][2*OUT_W-1 -: 2]};
            trial    = {q_reg[s], 2'b01};
            q_next   = {q_reg[s][OUT_W-2:0], 1'b0};
            if (rem_next >= trial)
            begin
                rem_next  = rem_next - trial;
                q_next[0] = 1'b1;
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (en)
                v_reg[s+1] <= v_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[s+1]  <= {n_reg[s][2*OUT_W-3:0], 2'b00};
                r_reg[s+1]  <= rem_next;
                q_reg[s+1]  <= q_next;
                sb_reg[s+1] <= sb_reg[s];
            end
        end
    end

    assign out_valid = v_reg[OUT_W];
    assign root      = q_reg[OUT_W];
    assign side_out  = sb_reg[OUT_W];

endmodule

### sv/rmq_div.sv
// Pipelined restoring divider: quotient = num / den, one bit per stage
module rmq_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 20,
    parameter int Q_W   = 18,
    parameter int SB_W  = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [SB_W-1:0]  side,
    output logic             out_valid,
    output logic [Q_W-1:0]   quo,
    output logic             big,
    output logic [SB_W-1:0]  side_out
);
    // Quotient bits above Q_W only flag saturation
    localparam int RW = NUM_W + 1;

    logic [Q_W:0]       v_reg;
    logic [RW-1:0]      r_reg  [Q_W+1];
    logic [DEN_W-1:0]   d_reg  [Q_W+1];
    logic [Q_W-1:0]     q_reg  [Q_W+1];
    logic [Q_W:0]       b_reg;
    logic [SB_W-1:0]    sb_reg [Q_W+1];
    logic [RW-1:0]      top_d;

    // Entry check: num >= den << Q_W means quotient overflows
    assign top_d = RW'(den) << Q_W;
    assign v_reg[0]  = in_valid;
    assign r_reg[0]  = RW'(num);
    assign d_reg[0]  = den;
    assign q_reg[0]  = '0;
    assign b_reg[0]  = (RW'(num) >= top_d);
    assign sb_reg[0] = side;

    for (genvar s = 0; s < Q_W; s++)
    begin : g_stage
        localparam int SH = Q_W - 1 - s;
        logic [RW-1:0]  shd;
        logic [RW-1:0]  r_next;
        logic [Q_W-1:0] q_next;
        always_comb
        begin
            shd    = RW'(d_reg[s]) << SH;
            r_next = r_reg[s];
            q_next = q_reg[s];
            if (!b_reg[s] && r_reg[s] >= shd)
            begin
                r_next     = r_reg[s] - shd;
                q_next[SH] = 1'b1;
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s+1] <= 1'b0;
            else if (en)
                v_reg[s+1] <= v_reg[s];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s+1]  <= r_next;
                d_reg[s+1]  <= d_reg[s];
                q_reg[s+1]  <= q_next;
                b_reg[s+1]  <= b_reg[s];
                sb_reg[s+1] <= sb_reg[s];
            end
        end
    end

    assign out_valid = v_reg[Q_W];
    assign quo       = q_reg[Q_W];
    assign big       = b_reg[Q_W];
    assign side_out  = sb_reg[Q_W];

endmodule

### tb/rmq_checker.sv
module rmq_checker #(
    parameter int DW = 16,
    parameter int FB = 14
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic signed [DW-1:0] m00,
    input  logic signed [DW-1:0] m01,
    input  logic signed [DW-1:0] m02,
    input  logic signed [DW-1:0] m10,
    input  logic signed [DW-1:0] m11,
    input  logic signed [DW-1:0] m12,
    input  logic signed [DW-1:0] m20,
    input  logic signed [DW-1:0] m21,
    input  logic signed [DW-1:0] m22,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic signed [DW-1:0] quat_w,
    input  logic signed [DW-1:0] quat_x,
    input  logic signed [DW-1:0] quat_y,
    input  logic signed [DW-1:0] quat_z,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DW-1:0] w;
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
    } quat_t;

    quat_t quat_q[$];

    assign pending = quat_q.size();

    // integer square root, bit by bit
    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // d/(2s), round to nearest, ties away from zero
    function automatic longint div_by_2s(longint d, longint unsigned s);
        longint unsigned mag;
        longint unsigned q;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q   = ((mag << FB) + s) / (s * 2);
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [DW-1:0] clip(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (DW - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            v = hi;
        if (v < lo)
            v = lo;
        return v[DW-1:0];
    endfunction

    function automatic quat_t matrix_to_quat(longint m[3][3]);
        longint          q[4];
        longint          one;
        longint          tr;
        longint          arg;
        longint unsigned s;
        int              i;
        int              j;
        int              k;
        quat_t           r;
        one = longint'(1) << FB;
        q   = '{0, 0, 0, 0};
        tr  = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0)
        begin
            s    = int_root(longint'(tr + one) << FB);
            q[0] = (s + 1) >> 1;
            q[1] = div_by_2s(m[2][1] - m[1][2], s);
            q[2] = div_by_2s(m[0][2] - m[2][0], s);
            q[3] = div_by_2s(m[1][0] - m[0][1], s);
        end
        else
        begin
            // strict compare: ties keep the lower index
            i = 0;
            if (m[1][1] > m[0][0])
                i = 1;
            if (m[2][2] > m[i][i])
                i = 2;
            j   = (i + 1) % 3;
            k   = (j + 1) % 3;
            arg = m[i][i] - (m[j][j] + m[k][k]) + one;
            if (arg < 0)
                arg = 0;
            s        = int_root(arg << FB);
            q[i + 1] = (s + 1) >> 1;
            if (s != 0)
            begin
                q[0]     = div_by_2s(m[k][j] - m[j][k], s);
                q[j + 1] = div_by_2s(m[i][j] + m[j][i], s);
                q[k + 1] = div_by_2s(m[i][k] + m[k][i], s);
            end
        end
        r.w = clip(q[0]);
        r.x = clip(q[1]);
        r.y = clip(q[2]);
        r.z = clip(q[3]);
        return r;
    endfunction

    // predict on input transfer, compare on output transfer
    always @(posedge clk)
    begin
        longint m[3][3];
        quat_t  exp_q;
        if (rst_n && in_valid && !in_stall)
        begin
            m[0][0] = m00; m[0][1] = m01; m[0][2] = m02;
            m[1][0] = m10; m[1][1] = m11; m[1][2] = m12;
            m[2][0] = m20; m[2][1] = m21; m[2][2] = m22;
            quat_q.push_back(matrix_to_quat(m));
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (quat_q.size() == 0)
            begin
                fail_count <= fail_count + 1;
                $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d",
                         $realtime, quat_w, quat_x, quat_y, quat_z);
            end
            else
            begin
                exp_q = quat_q.pop_front();
                if (exp_q.w !== quat_w || exp_q.x !== quat_x ||
                    exp_q.y !== quat_y || exp_q.z !== quat_z)
                begin
                    fail_count <= fail_count + 1;
                    $display("%0t: mismatch expected w=%0d x=%0d y=%0d z=%0d",
                             $realtime, exp_q.w, exp_q.x, exp_q.y, exp_q.z);
                    $display("%0t:          actual   w=%0d x=%0d y=%0d z=%0d",
                             $realtime, quat_w, quat_x, quat_y, quat_z);
                end
            end
        end
    end

endmodule

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW        = 16;
    localparam int FB        = 14;
    localparam int LATENCY   = 2 * (DW + 3) + 3;
    localparam int N_RANDOM  = 1400;
    localparam int MAX_CYCLE = 200000;
    localparam logic signed [DW-1:0] ONE  = 16'sd16384;
    localparam logic signed [DW-1:0] MAXV = 16'sh7fff;
    localparam logic signed [DW-1:0] MINV = 16'sh8000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [DW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic signed [DW-1:0] quat_w, quat_x, quat_y, quat_z;
    int fail_count;
    int pending;
    int cycle_count = 0;
    bit calm;

    rotation_matrix_to_quaternion #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (.*);

    rmq_checker #(.DW(DW), .FB(FB)) u_checker (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // receiver stall, quiet during calm stretch
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 29);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic signed [DW-1:0] rand_elem(int mode);
        case (mode)
            0: return DW'($urandom);
            1: return $signed(DW'($urandom_range(32767))) - 16'sd16384;
            default: return $urandom_range(3) == 0 ? ONE : -ONE;
        endcase
    endfunction

    // one matrix transfer, with random idle beforehand
    task automatic send_matrix(input logic signed [DW-1:0] a[9]);
        while (!calm && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} <=
            {a[0], a[1], a[2], a[3], a[4], a[5], a[6], a[7], a[8]};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // permutation-like matrix with random signs, near rotation
    task automatic rotation_like(output logic signed [DW-1:0] a[9]);
        int p;
        int r;
        p = $urandom_range(5);
        for (r = 0; r < 9; r++)
            a[r] = $signed(DW'($urandom_range(600))) - 16'sd300;
        for (r = 0; r < 3; r++)
            a[r * 3 + ((r + p) % 3)] = ($urandom_range(1) ? ONE : -ONE)
                                       - $signed(DW'($urandom_range(2000)));
    endtask

    initial
    begin
        logic signed [DW-1:0] a[9];
        int n;
        int r;
        int mode;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        calm        = 1'b0;
        {m00, m01, m02, m10, m11, m12, m20, m21, m22} = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, half turns, ties, zero matrix, extremes
        a = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};             send_matrix(a);
        a = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE};           send_matrix(a);
        a = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE};           send_matrix(a);
        a = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE};           send_matrix(a);
        a = '{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE};            send_matrix(a);
        a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                   send_matrix(a);
        a = '{-ONE, 5, 7, 9, -ONE, 3, 1, 2, -ONE};          send_matrix(a);
        a = '{MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV}; send_matrix(a);
        a = '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV}; send_matrix(a);
        a = '{MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV, MINV}; send_matrix(a);
        a = '{MINV, MAXV, MINV, MAXV, MAXV, MINV, MAXV, MINV, MAXV}; send_matrix(a);
        a = '{MINV, 0, 0, 0, MAXV, 0, 0, 0, MAXV};          send_matrix(a);
        a = '{1, MAXV, MINV, MINV, 0, MAXV, MAXV, MINV, -1}; send_matrix(a);
        a = '{-ONE, 100, -200, 300, -ONE, 400, -500, 600, -2}; send_matrix(a);
        a = '{-3, 100, -200, 300, -3, 400, -500, 600, -3};  send_matrix(a);
        a = '{-1, MAXV, MAXV, MINV, -1, MAXV, MINV, MINV, 0}; send_matrix(a);

        // random: mostly rotation-like, some wide noise; calm stretch in the middle
        for (n = 0; n < N_RANDOM; n++)
        begin
            calm = (n >= 500 && n < 700);
            mode = $urandom_range(9);
            if (mode < 6)
                rotation_like(a);
            else
                for (r = 0; r < 9; r++)
                    a[r] = rand_elem(mode == 9 ? 2 : (mode == 8 ? 1 : 0));
            send_matrix(a);
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
